// File: hw/rtl/fpa_pkg.sv
// Package for the fixed-point ALU: operation codes, the request record and defaults.
// Used by fpa_front, fpa_back and fixed_point_alu; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

    localparam int DEFAULT_FRACTION_BITS = 8;
    localparam int DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_LT   = 4'd4,
        OP_GT   = 4'd5,
        OP_LE   = 4'd6,
        OP_GE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_ITOF = 4'd14,
        OP_FTOI = 4'd15
    } op_t;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic is_cmp;
    } op_class_t;

    typedef struct packed {
        op_t                op;
        op_class_t          cls;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
    } req_t;

endpackage
`default_nettype wire

// File: hw/rtl/fpa_front.sv
// Front end of the fixed-point ALU: takes request beats, classifies them, queues them.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpa_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [3:0]                 s_req_type,
    input  wire logic [fpa_pkg::DATA_W-1:0] s_operand_a,
    input  wire logic [fpa_pkg::DATA_W-1:0] s_operand_b,
    output logic                            q_valid,
    input  wire logic                       q_pop,
    output fpa_pkg::req_t                   q_head
);

    fpa_pkg::req_t mem_reg [0:fpa_pkg::QUEUE_DEPTH-1];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    fpa_pkg::req_t incoming;
    logic          push, pop;

    always_comb begin
        incoming.op         = fpa_pkg::op_t'(s_req_type);
        incoming.a          = s_operand_a;
        incoming.b          = s_operand_b;
        incoming.cls.is_mul = (incoming.op == fpa_pkg::OP_MUL);
        incoming.cls.is_div = (incoming.op == fpa_pkg::OP_DIV);
        case (incoming.op) inside
            fpa_pkg::OP_LT, fpa_pkg::OP_GT, fpa_pkg::OP_LE,
            fpa_pkg::OP_GE, fpa_pkg::OP_EQ, fpa_pkg::OP_NE: incoming.cls.is_cmp = 1'b1;
            default: incoming.cls.is_cmp = 1'b0;
        endcase
    end

    assign s_ready = (count_reg != 2'(fpa_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;
    assign q_valid = (count_reg != 2'd0);
    assign q_head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/fpa_back.sv
// Back end of the fixed-point ALU: execution pipeline with a bit-per-stage divider.
// Depends on fpa_pkg; fed by fpa_front.
`timescale 1ns / 1ps
`default_nettype none
module fpa_back #(
    parameter int FRACTION_BITS = fpa_pkg::DEFAULT_FRACTION_BITS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_valid,
    output logic                            q_pop,
    input  wire fpa_pkg::req_t              q_head,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [fpa_pkg::DATA_W-1:0]      m_result_value,
    output logic                            m_compare_true,
    output logic                            m_status
);

    localparam int W  = fpa_pkg::DATA_W;
    localparam int NW = W + FRACTION_BITS;

    typedef struct packed {
        fpa_pkg::op_class_t cls;
        logic [W-1:0]       res;
        logic               cmp;
        logic               st;
        logic [2*W-1:0]     prod;
        logic [NW-1:0]      num;
        logic [W-1:0]       den;
        logic [W-1:0]       rem;
        logic               neg;
    } stage_t;

    stage_t pipe_reg  [0:NW];
    stage_t pipe_next [0:NW];
    logic [NW:0] vld_reg, vld_next;
    logic        adv;

    function automatic stage_t div_step(stage_t s);
        logic [W:0] r;
        logic       ge;
        stage_t     o;
        o  = s;
        r  = {s.rem, s.num[NW-1]};
        ge = (r >= {1'b0, s.den});
        o.rem = ge ? W'(r - {1'b0, s.den}) : r[W-1:0];
        o.num = {s.num[NW-2:0], ge};
        return o;
    endfunction

    assign adv   = !vld_reg[NW] || m_ready;
    assign q_pop = adv;

    always_comb begin
        logic signed [W-1:0] a, b;
        logic [W-1:0]        mag_a;
        a = $signed(q_head.a);
        b = $signed(q_head.b);
        mag_a = a[W-1] ? W'(-a) : a;
        pipe_next[0].cls  = q_head.cls;
        pipe_next[0].res  = '0;
        pipe_next[0].cmp  = 1'b0;
        pipe_next[0].st   = 1'b0;
        pipe_next[0].prod = a * b;
        pipe_next[0].num  = {mag_a, {FRACTION_BITS{1'b0}}};
        pipe_next[0].den  = b[W-1] ? W'(-b) : b;
        pipe_next[0].rem  = '0;
        pipe_next[0].neg  = a[W-1] ^ b[W-1];
        unique case (q_head.op)
            fpa_pkg::OP_ADD:  pipe_next[0].res = a + b;
            fpa_pkg::OP_SUB:  pipe_next[0].res = a - b;
            fpa_pkg::OP_MUL:  pipe_next[0].res = '0;
            fpa_pkg::OP_DIV:  pipe_next[0].st  = (b == '0);
            fpa_pkg::OP_LT:   pipe_next[0].cmp = (a < b);
            fpa_pkg::OP_GT:   pipe_next[0].cmp = (a > b);
            fpa_pkg::OP_LE:   pipe_next[0].cmp = (a <= b);
            fpa_pkg::OP_GE:   pipe_next[0].cmp = (a >= b);
            fpa_pkg::OP_EQ:   pipe_next[0].cmp = (a == b);
            fpa_pkg::OP_NE:   pipe_next[0].cmp = (a != b);
            fpa_pkg::OP_MIN:  pipe_next[0].res = (a < b) ? a : b;
            fpa_pkg::OP_MAX:  pipe_next[0].res = (a > b) ? a : b;
            fpa_pkg::OP_INC:  pipe_next[0].res = a + W'(1);
            fpa_pkg::OP_DEC:  pipe_next[0].res = a - W'(1);
            fpa_pkg::OP_ITOF: pipe_next[0].res = a << FRACTION_BITS;
            fpa_pkg::OP_FTOI: pipe_next[0].res = a >>> FRACTION_BITS;
            default:          pipe_next[0].res = '0;
        endcase

        for (int k = 1; k <= NW; k++) begin
            pipe_next[k] = div_step(pipe_reg[k-1]);
            // The registered product is scaled one stage after the multiplier.
            if (k == 1 && pipe_reg[k-1].cls.is_mul) begin
                pipe_next[k].res = pipe_reg[k-1].prod[FRACTION_BITS+W-1:FRACTION_BITS];
            end
            // After the last step the quotient gets its sign and wraps to 32 bits.
            if (k == NW && pipe_reg[k-1].cls.is_div) begin
                if (pipe_reg[k-1].st) begin
                    pipe_next[k].res = '0;
                end else if (pipe_reg[k-1].neg) begin
                    pipe_next[k].res = W'(-pipe_next[k].num);
                end else begin
                    pipe_next[k].res = pipe_next[k].num[W-1:0];
                end
            end
        end
        vld_next = {vld_reg[NW-1:0], q_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k <= NW; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign m_valid        = vld_reg[NW];
    assign m_result_value = pipe_reg[NW].res;
    assign m_compare_true = pipe_reg[NW].cmp;
    assign m_status       = pipe_reg[NW].st;

endmodule
`default_nettype wire

// File: hw/rtl/fixed_point_alu.sv
// Top level of the signed fixed-point ALU: request queue front end and execution back end.
// Depends on fpa_pkg, fpa_front and fpa_back.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Direction  Handshake           Beat contents
//  s_        in         s_valid / s_ready   s_req_type, s_operand_a, s_operand_b
//  m_        out        m_valid / m_ready   m_result_value, m_compare_true, m_status
//
// One request beat is accepted every cycle while the queue has room, and one result
// beat leaves every cycle while m_ready is high. A request beat passes through the queue,
// the operand stage and one divider stage per quotient bit, as the divider resolves one
// bit per pipeline stage; every operation travels the same stages so results leave in
// request order.
// Reset is synchronous on aresetn and clears the queue count and the stage valid bits.
// A stall on m_ready while a result beat is presented freezes the whole execution
// pipeline; the two-entry queue keeps s_ready high until it fills.
//
module fixed_point_alu #(
    parameter int FRACTION_BITS = fpa_pkg::DEFAULT_FRACTION_BITS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [3:0]                 s_req_type,
    input  wire logic [fpa_pkg::DATA_W-1:0] s_operand_a,
    input  wire logic [fpa_pkg::DATA_W-1:0] s_operand_b,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [fpa_pkg::DATA_W-1:0]      m_result_value,
    output logic                            m_compare_true,
    output logic                            m_status
);

    // Queue head handed from the front end to the back end.
    logic          q_valid;
    logic          q_pop;
    fpa_pkg::req_t q_head;

    // The front end decodes each beat and holds it until the pipeline takes it.
    fpa_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_head      (q_head)
    );

    // The back end computes the result; its last stage is the output register.
    fpa_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_head         (q_head),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_compare_true (m_compare_true),
        .m_status       (m_status)
    );

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the fixed-point ALU top level fixed_point_alu.
// Depends on fpa_pkg and the RTL; predicts every result beat and compares it in order.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int FB = fpa_pkg::DEFAULT_FRACTION_BITS;
    localparam int LATENCY = FB + 34;
    localparam int CYCLE_LIMIT = 200000;

    // Expected result of one request, as it should leave the block.
    typedef struct {
        logic [31:0] value;
        logic        cmp;
        logic        status;
    } alu_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_req_type = 4'd0;
    logic [31:0] s_operand_a = '0;
    logic [31:0] s_operand_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_result_value;
    logic        m_compare_true;
    logic        m_status;

    alu_result_t pending_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    // Receiver behavior: random stalls, a long hold-off, or always ready.
    bit          rx_stalls = 1'b1;
    int          rx_holdoff = 0;
    bit          tx_gaps = 1'b1;

    always #6 aclk = ~aclk;

    fixed_point_alu #(.FRACTION_BITS(FB)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_value(m_result_value),
        .m_compare_true(m_compare_true), .m_status(m_status)
    );

    // Computes the result that one request should produce.
    function automatic alu_result_t alu_predict(fpa_pkg::op_t op, logic signed [31:0] a,
                                                logic signed [31:0] b);
        alu_result_t       r;
        logic signed [63:0] wide;
        r.value = '0;
        r.cmp = 1'b0;
        r.status = 1'b0;
        case (op)
            fpa_pkg::OP_ADD:  r.value = a + b;
            fpa_pkg::OP_SUB:  r.value = a - b;
            fpa_pkg::OP_MUL: begin
                wide = 64'(a) * 64'(b);
                r.value = 32'(wide >>> FB);
            end
            fpa_pkg::OP_DIV: begin
                if (b == 0) begin
                    r.status = 1'b1;
                end else begin
                    // The widened dividend cannot overflow, so the quotient fits 64 bits.
                    wide = (64'(a) <<< FB) / 64'(b);
                    r.value = wide[31:0];
                end
            end
            fpa_pkg::OP_LT:   r.cmp = a < b;
            fpa_pkg::OP_GT:   r.cmp = a > b;
            fpa_pkg::OP_LE:   r.cmp = a <= b;
            fpa_pkg::OP_GE:   r.cmp = a >= b;
            fpa_pkg::OP_EQ:   r.cmp = a == b;
            fpa_pkg::OP_NE:   r.cmp = a != b;
            fpa_pkg::OP_MIN:  r.value = (a < b) ? a : b;
            fpa_pkg::OP_MAX:  r.value = (a > b) ? a : b;
            fpa_pkg::OP_INC:  r.value = a + 1;
            fpa_pkg::OP_DEC:  r.value = a - 1;
            fpa_pkg::OP_ITOF: r.value = a << FB;
            default:          r.value = a >>> FB;
        endcase
        return r;
    endfunction

    // Sends one request beat and records its expected result when it is taken.
    task automatic send_request(fpa_pkg::op_t op, logic [31:0] a, logic [31:0] b);
        int gap;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(alu_predict(op, a, b));
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every expected result beat has been received.
    task automatic drain_results();
        idle_sender();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 | $urandom_range(0, 3);
            1: return 32'h7fff_fffc | $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 2047)) - 1024);
            3: return $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stall bursts, or a long counted hold-off when requested.
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (rx_holdoff > 0) begin
                m_ready <= 1'b0;
                repeat (rx_holdoff) @(posedge aclk);
                rx_holdoff = 0;
            end
            if (rx_stalls && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 19);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Checker: every accepted result beat is compared with the oldest expectation.
    always @(posedge aclk) begin
        alu_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: value %h", $time,
                         m_result_value);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_result_value !== exp_r.value) begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             exp_r.value, m_result_value);
                    error_count++;
                end
                if (m_compare_true !== exp_r.cmp) begin
                    $display("%0t: compare_true expected %b actual %b", $time,
                             exp_r.cmp, m_compare_true);
                    error_count++;
                end
                if (m_status !== exp_r.status) begin
                    $display("%0t: status expected %b actual %b", $time,
                             exp_r.status, m_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Every operation against the operand extremes, plus divide by zero and the
    // divide case whose quotient wraps.
    task automatic test_directed();
        fpa_pkg::op_t op;
        send_request(fpa_pkg::OP_DIV, 32'h0000_0100, 32'd0);
        send_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0001);
        send_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_request(fpa_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_request(fpa_pkg::OP_FTOI, 32'hffff_ff01, 32'd0);
        send_request(fpa_pkg::OP_ITOF, 32'h0080_0000, 32'd0);
        send_request(fpa_pkg::OP_EQ, 32'h1234_5678, 32'h1234_5678);
        for (int i = 0; i < 16; i++) begin
            op = fpa_pkg::op_t'(i);
            send_request(op, (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff,
                         (i % 2) ? 32'h7fff_ffff : 32'h8000_0000);
        end
        drain_results();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_request(fpa_pkg::op_t'($urandom_range(0, 15)), random_operand(),
                         random_operand());
    endtask

    // The receiver holds off while the sender keeps offering beats, so the pipeline
    // and queue fill and s_ready must drop.
    task automatic test_backpressure();
        drain_results();
        tx_gaps = 1'b0;
        rx_holdoff = 3 * LATENCY;
        test_random(80);
        drain_results();
        tx_gaps = 1'b1;
    endtask

    // Closing stretch at full rate with no idling on either side.
    task automatic test_full_rate();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        test_random(80);
        drain_results();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(266);
        test_backpressure();
        test_full_rate();
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: fixed_point_alu.f
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_back.sv
hw/rtl/fixed_point_alu.sv
bench/tb_top.sv
